@@ rtl/mhpq_pkg.sv @@
// mhpq_pkg: shared types and constants of the max-heap priority queue core
// no dependencies; used by mhpq_cell and max_heap_priority_queue_core
`default_nettype none

package mhpq_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/mhpq_cell.sv @@
// mhpq_cell: one slot of the sorted cell row, largest value toward cell 0
// depends on mhpq_pkg for the command struct
`default_nettype none

module mhpq_cell #(
    parameter int VALUE_WIDTH = mhpq_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire mhpq_pkg::t_cell_ctl    i_ctl,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic                   i_occupied,
    input  wire logic [VALUE_WIDTH-1:0] i_left_value,
    input  wire logic                   i_left_keep,
    input  wire logic [VALUE_WIDTH-1:0] i_right_value,
    output logic      [VALUE_WIDTH-1:0] o_value,
    output logic      [VALUE_WIDTH-1:0] o_next_value,
    output logic                        o_keep
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    // slot holds its value when it is filled and not below the new one
    assign o_keep = i_occupied && ($signed(r_value) >= $signed(i_value));

    always_comb begin
        n_value = r_value;
        if (i_ctl.insert) begin
            if (o_keep) begin
                n_value = r_value;
            end else if (i_left_keep) begin
                n_value = i_value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctl.remove) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule

`default_nettype wire

@@ rtl/max_heap_priority_queue_core.sv @@
// max_heap_priority_queue_core: top level of the priority queue
// depends on mhpq_pkg and mhpq_cell
//
// Usage: the slave channel takes one command per beat, tuser selects insert
// (0) or remove of the largest value (1), tdata carries the value to insert.
// The master channel returns one result beat per command: removed value,
// new largest value, entry count, empty flag and a status code (ok, remove
// on empty, insert when full; a rejected command leaves the contents alone).
// Values sit in a row of CAPACITY cells kept in descending order; every cell
// compares the broadcast value with its own and takes its own, the new or
// its left neighbor's value on insert, or its right neighbor's on remove.
// The result beat is registered, and one command is taken every cycle unless
// the receiver stalls; each cell needs only a single compare per command.
// Reset empties the queue and drops any pending result. When the receiver
// stalls, the result register holds its beat and tready falls until the
// beat is taken, so no command is lost.
`default_nettype none

module max_heap_priority_queue_core #(
    parameter int CAPACITY    = mhpq_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = mhpq_pkg::DEF_VALUE_WIDTH,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IN_W       = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW_W  = 2 * VALUE_WIDTH + CNT_W + 3,
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [IN_W-1:0]  i_s_tdata,  // value
    input  wire logic             i_s_tuser,  // action
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic      [OUT_W-1:0] o_m_tdata   // removed_value, top_value, entry_count,
                                              // is_empty, status
);

    logic                      w_accept;
    logic [VALUE_WIDTH-1:0]    w_value;
    logic                      w_insert_ok;
    logic                      w_remove_ok;
    mhpq_pkg::t_cell_ctl       w_ctl;
    mhpq_pkg::t_status         w_status;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_m_valid;
    logic                      n_m_valid;
    logic [OUT_RAW_W-1:0]      r_m_data;
    logic [OUT_RAW_W-1:0]      n_m_data;
    logic [VALUE_WIDTH-1:0]    w_removed;
    logic [VALUE_WIDTH-1:0]    w_top;

    logic [VALUE_WIDTH-1:0]    w_cell_val  [CAPACITY];
    logic [VALUE_WIDTH-1:0]    w_cell_next [CAPACITY];
    logic                      w_cell_keep [CAPACITY];

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_value    = i_s_tdata[VALUE_WIDTH-1:0];

    assign w_insert_ok = (i_s_tuser == mhpq_pkg::ACT_INSERT) && (r_count < CNT_W'(CAPACITY));
    assign w_remove_ok = (i_s_tuser == mhpq_pkg::ACT_REMOVE) && (r_count != '0);

    assign w_ctl.insert = w_accept && w_insert_ok;
    assign w_ctl.remove = w_accept && w_remove_ok;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                   w_left_keep;
            logic [VALUE_WIDTH-1:0] w_left_value;
            logic [VALUE_WIDTH-1:0] w_right_value;

            if (g == 0) begin : g_first
                assign w_left_keep  = 1'b1;
                assign w_left_value = w_value;
            end else begin : g_mid
                assign w_left_keep  = w_cell_keep[g-1];
                assign w_left_value = w_cell_val[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right_value = '0;
            end else begin : g_inner
                assign w_right_value = w_cell_val[g+1];
            end

            mhpq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_value       (w_value),
                .i_occupied    (CNT_W'(g) < r_count),
                .i_left_value  (w_left_value),
                .i_left_keep   (w_left_keep),
                .i_right_value (w_right_value),
                .o_value       (w_cell_val[g]),
                .o_next_value  (w_cell_next[g]),
                .o_keep        (w_cell_keep[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        w_status = mhpq_pkg::ST_OK;
        if (i_s_tuser == mhpq_pkg::ACT_INSERT) begin
            if (w_insert_ok) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                w_status = mhpq_pkg::ST_FULL;
            end
        end else begin
            if (w_remove_ok) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                w_status = mhpq_pkg::ST_EMPTY;
            end
        end
    end

    assign w_removed = w_remove_ok ? w_cell_val[0] : '0;
    assign w_top     = (n_count != '0) ? w_cell_next[0] : '0;

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (w_accept) begin
            n_m_valid = 1'b1;
            n_m_data  = {w_status, (n_count == '0), n_count, w_top, w_removed};
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_W'(r_m_data);

endmodule

`default_nettype wire
